[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; they expect clk_i and rst_ni in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/ipe_pkg.sv]
// ----------------------------------------------------------------------------
// ipe_pkg
// Constants, types and helpers of the inductor position error block.
// ----------------------------------------------------------------------------
package ipe_pkg;

  localparam int SAMPLES_PER_READING = 4;
  localparam int SAMPLE_BITS         = 12;

  localparam int CHANNELS  = 5;
  localparam int IN_W      = 12;
  localparam int AVG_OUT_W = 12;
  localparam int ERR_W     = 16;
  localparam int MAG_SHIFT = 8;

  localparam int CH_LEFT_OUTER  = 0;
  localparam int CH_LEFT_INNER  = 1;
  localparam int CH_MIDDLE      = 2;
  localparam int CH_RIGHT_INNER = 3;
  localparam int CH_RIGHT_OUTER = 4;

  localparam int N_EFF    = (SAMPLES_PER_READING < 1) ? 1 : SAMPLES_PER_READING;
  localparam int CNT_W    = (N_EFF > 1) ? $clog2(N_EFF) : 1;
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int AVG_W    = SAMPLE_BITS;
  // 256 * (a^2 + b^2) fits in MAG_W bits
  localparam int MAG_W    = 2 * SAMPLE_BITS + MAG_SHIFT + 1;
  localparam int SQ_STEPS = (MAG_W + 1) / 2;
  localparam int ROOT_W   = SQ_STEPS;
  // |a-b| <= a+b keeps the quotient below 2^ERR_W
  localparam int DIV_STEPS = ERR_W;

  localparam logic [ERR_W-1:0] ERR_MAX = ERR_W'(32767);

  typedef logic [SAMPLE_BITS-1:0]    sample_t;
  typedef sample_t [CHANNELS-1:0]    sample_arr_t;
  typedef logic [AVG_W-1:0]          avg_t;
  typedef avg_t [CHANNELS-1:0]       avg_arr_t;
  typedef logic [ROOT_W-1:0]         root_t;

  // keep the low SAMPLE_BITS bits of a reading
  function automatic sample_t trim_sample(logic [IN_W-1:0] raw);
    logic [IN_W+SAMPLE_BITS-1:0] wide;
    wide = {{SAMPLE_BITS{1'b0}}, raw};
    return wide[SAMPLE_BITS-1:0];
  endfunction

  // give out the low bits of an average
  function automatic logic [AVG_OUT_W-1:0] avg_to_out(avg_t a);
    logic [AVG_OUT_W+AVG_W-1:0] wide;
    wide = {{AVG_OUT_W{1'b0}}, a};
    return wide[AVG_OUT_W-1:0];
  endfunction

endpackage

[rtl/ipe_if.sv]
// ----------------------------------------------------------------------------
// ipe_if
// Valid/ready channels for sensor items and position results.
// ----------------------------------------------------------------------------
interface ipe_in_if;
  import ipe_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] sample_left_outer;
  logic [IN_W-1:0] sample_left_inner;
  logic [IN_W-1:0] sample_middle;
  logic [IN_W-1:0] sample_right_inner;
  logic [IN_W-1:0] sample_right_outer;
  logic            cross_mode;

  modport source (output valid, sample_left_outer, sample_left_inner, sample_middle,
                  sample_right_inner, sample_right_outer, cross_mode, input ready);
  modport sink   (input valid, sample_left_outer, sample_left_inner, sample_middle,
                  sample_right_inner, sample_right_outer, cross_mode, output ready);
endinterface

interface ipe_out_if;
  import ipe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [AVG_OUT_W-1:0]    avg_left_outer;
  logic [AVG_OUT_W-1:0]    avg_left_inner;
  logic [AVG_OUT_W-1:0]    avg_middle;
  logic [AVG_OUT_W-1:0]    avg_right_inner;
  logic [AVG_OUT_W-1:0]    avg_right_outer;
  logic signed [ERR_W-1:0] position_error;

  modport source (output valid, avg_left_outer, avg_left_inner, avg_middle,
                  avg_right_inner, avg_right_outer, position_error, input ready);
  modport sink   (input valid, avg_left_outer, avg_left_inner, avg_middle,
                  avg_right_inner, avg_right_outer, position_error, output ready);
endinterface

[rtl/ipe_accum.sv]
// ----------------------------------------------------------------------------
// ipe_accum
// Per-channel sums and item count; bit-serial division of each sum by the
// item count per reading, one quotient bit per cycle in every lane.
// ----------------------------------------------------------------------------
module ipe_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 add_i,
  input  ipe_pkg::sample_arr_t sample_i,
  input  logic                 clear_i,
  output logic                 last_o,
  output logic                 busy_o,
  output logic                 done_o,
  output ipe_pkg::avg_arr_t    avg_o
);
  import ipe_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [CNT_W:0] N_CMP = (CNT_W+1)'(N_EFF);

  logic [CHANNELS-1:0][SUM_W-1:0] sum_q, sum_d;
  logic [CHANNELS-1:0][CNT_W-1:0] rem_q, rem_d;
  logic [CHANNELS-1:0][CNT_W:0]   shifted, part;
  logic [CHANNELS-1:0]            qbit;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;

  assign last_o = (cnt_q == CNT_W'(N_EFF - 1));
  assign busy_o = busy_q;
  assign done_o = done_q;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      shifted[c] = {rem_q[c], sum_q[c][SUM_W-1]};
      qbit[c]    = (shifted[c] >= N_CMP);
      part[c]    = qbit[c] ? (shifted[c] - N_CMP) : shifted[c];
      avg_o[c]   = (sum_q[c] == '0) ? AVG_W'(1) : sum_q[c][AVG_W-1:0];
    end
  end

  always_comb begin
    sum_d  = sum_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (clear_i) begin
      sum_d = '0;
    end else if (busy_q) begin
      // shift the quotient bit into the sum register from below
      for (int c = 0; c < CHANNELS; c++) begin
        rem_d[c] = part[c][CNT_W-1:0];
        sum_d[c] = {sum_q[c][SUM_W-2:0], qbit[c]};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (add_i) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_d[c] = sum_q[c] + SUM_W'(sample_i[c]);
      end
      if (last_o) begin
        cnt_d  = '0;
        busy_d = 1'b1;
        step_d = '0;
        rem_d  = '0;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

[rtl/ipe_mag.sv]
// ----------------------------------------------------------------------------
// ipe_mag
// Vector magnitude floor(sqrt(256*(a^2+b^2))): shift-add squaring one
// multiplier bit per cycle, then a square root one result bit per cycle.
// ----------------------------------------------------------------------------
module ipe_mag (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ipe_pkg::avg_t  a_i,
  input  ipe_pkg::avg_t  b_i,
  output logic           done_o,
  output ipe_pkg::root_t root_o
);
  import ipe_pkg::*;

  localparam int PROD_W   = 2 * AVG_W + 1;
  localparam int MCAND_W  = 2 * AVG_W;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int REM_W    = ROOT_W + 2;
  localparam int MAX_STEP = (AVG_W > SQ_STEPS) ? AVG_W : SQ_STEPS;
  localparam int STEP_W   = $clog2(MAX_STEP + 1);

  localparam logic [1:0] MG_IDLE  = 2'd0;
  localparam logic [1:0] MG_MUL_A = 2'd1;
  localparam logic [1:0] MG_MUL_B = 2'd2;
  localparam logic [1:0] MG_ROOT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [PROD_W-1:0]  acc_q, acc_d, acc_next;
  logic [MCAND_W-1:0] mcand_q, mcand_d;
  logic [AVG_W-1:0]   mplier_q, mplier_d;
  logic [RAD_W-1:0]   rad_q, rad_d;
  logic [REM_W-1:0]   rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic               done_q, done_d;

  assign done_o = done_q;
  assign root_o = root_q;

  assign acc_next = acc_q + (mplier_q[0] ? PROD_W'(mcand_q) : PROD_W'(0));
  assign rem_sh   = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial    = {root_q, 2'b01};

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    done_d   = 1'b0;
    unique case (state_q)
      MG_IDLE: begin
        if (start_i) begin
          acc_d    = '0;
          mcand_d  = MCAND_W'(a_i);
          mplier_d = a_i;
          step_d   = '0;
          state_d  = MG_MUL_A;
        end
      end
      MG_MUL_A: begin
        acc_d    = acc_next;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(AVG_W - 1)) begin
          mcand_d  = MCAND_W'(b_i);
          mplier_d = b_i;
          step_d   = '0;
          state_d  = MG_MUL_B;
        end
      end
      MG_MUL_B: begin
        acc_d    = acc_next;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(AVG_W - 1)) begin
          rad_d   = RAD_W'(acc_next) << MAG_SHIFT;
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = MG_ROOT;
        end
      end
      MG_ROOT: begin
        // bring in two radicand bits, try the next root bit
        rad_d  = rad_q << 2;
        step_d = step_q + STEP_W'(1);
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (step_q == STEP_W'(SQ_STEPS - 1)) begin
          done_d  = 1'b1;
          state_d = MG_IDLE;
        end
      end
      default: state_d = MG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MG_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rad_q    <= rad_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
  end

endmodule

[rtl/ipe_ratio.sv]
// ----------------------------------------------------------------------------
// ipe_ratio
// Signed Q0.15 ratio (a-b)/(a+b), truncated toward zero and saturated;
// restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ipe_ratio (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  ipe_pkg::root_t                a_i,
  input  ipe_pkg::root_t                b_i,
  output logic                          done_o,
  output logic signed [ipe_pkg::ERR_W-1:0] err_o
);
  import ipe_pkg::*;

  localparam int OPS_W  = ROOT_W + 1;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic [OPS_W-1:0]     den_q, den_d;
  logic [ROOT_W-1:0]    diff;
  logic [REM_W-1:0]     rem_q, rem_d, rem_sh;
  logic [DIV_STEPS-1:0] feed_q, feed_d, quo_q, quo_d;
  logic [ERR_W-1:0]     sat;
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 neg_q, neg_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic signed [ERR_W-1:0] err_q, err_d;

  assign done_o = done_q;
  assign err_o  = err_q;

  assign diff   = (a_i >= b_i) ? (a_i - b_i) : (b_i - a_i);
  assign rem_sh = {rem_q[REM_W-2:0], feed_q[DIV_STEPS-1]};

  always_comb begin
    den_d  = den_q;
    rem_d  = rem_q;
    feed_d = feed_q;
    quo_d  = quo_q;
    step_d = step_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    err_d  = err_q;
    sat    = '0;
    if (busy_q) begin
      feed_d = feed_q << 1;
      step_d = step_q + STEP_W'(1);
      if (rem_sh >= REM_W'(den_q)) begin
        rem_d = rem_sh - REM_W'(den_q);
        quo_d = {quo_q[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DIV_STEPS-2:0], 1'b0};
      end
      if (step_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        sat    = (quo_d > ERR_MAX) ? ERR_MAX : quo_d;
        err_d  = neg_q ? -$signed(sat) : $signed(sat);
      end
    end else if (start_i) begin
      // dividend is diff * 2^15; its bits above the quotient width start the remainder
      den_d  = OPS_W'(a_i) + OPS_W'(b_i);
      neg_d  = (a_i < b_i);
      rem_d  = REM_W'(diff >> 1);
      feed_d = {diff[0], {(DIV_STEPS-1){1'b0}}};
      quo_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    feed_q <= feed_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    err_q  <= err_d;
  end

endmodule

[rtl/inductor_position_error.sv]
// Sequence: an item that does not complete a reading is added to the sums; the
// item that completes one starts the count division, then in vector mode the
// squarings and square roots, then the ratio division, one bit per cycle each;
// cross mode goes from the count division straight to the ratio division.
// Throughput: one item per cycle within a reading; input stalls until the
// result enters the output register. Reset clears sums, count and control.
// ----------------------------------------------------------------------------
// inductor_position_error
// Averages five sensor channels over a reading and forms a Q0.15
// difference-over-sum position error.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module inductor_position_error (
  input logic       clk_i,
  input logic       rst_ni,
  ipe_in_if.sink    in_i,
  ipe_out_if.source out_o
);
  import ipe_pkg::*;

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MAG   = 3'd2;
  localparam logic [2:0] ST_RATIO = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NEG_FULL = {1'b1, {(ERR_W-1){1'b0}}};

  logic [2:0]  state_q, state_d;
  logic        cross_q, cross_d;
  logic        accept, load_out;
  sample_arr_t sample_arr;
  avg_arr_t    avg;
  logic        acc_last, acc_busy, acc_done;
  logic        mag_start, mag_l_done, mag_r_done;
  root_t       root_l, root_r, ratio_a, ratio_b;
  logic        ratio_start, ratio_done;
  logic signed [ERR_W-1:0] ratio_err;

  logic                    out_valid_q, out_valid_d;
  avg_arr_t                avg_out_q;
  logic signed [ERR_W-1:0] err_out_q;

  assign in_i.ready = (state_q == ST_ACC);
  assign accept     = in_i.valid & in_i.ready;

  assign sample_arr[CH_LEFT_OUTER]  = trim_sample(in_i.sample_left_outer);
  assign sample_arr[CH_LEFT_INNER]  = trim_sample(in_i.sample_left_inner);
  assign sample_arr[CH_MIDDLE]      = trim_sample(in_i.sample_middle);
  assign sample_arr[CH_RIGHT_INNER] = trim_sample(in_i.sample_right_inner);
  assign sample_arr[CH_RIGHT_OUTER] = trim_sample(in_i.sample_right_outer);

  ipe_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .add_i    (accept),
    .sample_i (sample_arr),
    .clear_i  (load_out),
    .last_o   (acc_last),
    .busy_o   (acc_busy),
    .done_o   (acc_done),
    .avg_o    (avg)
  );

  ipe_mag u_mag_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mag_start),
    .a_i     (avg[CH_LEFT_OUTER]),
    .b_i     (avg[CH_LEFT_INNER]),
    .done_o  (mag_l_done),
    .root_o  (root_l)
  );

  ipe_mag u_mag_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mag_start),
    .a_i     (avg[CH_RIGHT_INNER]),
    .b_i     (avg[CH_RIGHT_OUTER]),
    .done_o  (mag_r_done),
    .root_o  (root_r)
  );

  assign ratio_a = cross_q ? ROOT_W'(avg[CH_LEFT_OUTER])  : root_l;
  assign ratio_b = cross_q ? ROOT_W'(avg[CH_RIGHT_OUTER]) : root_r;

  ipe_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ratio_start),
    .a_i     (ratio_a),
    .b_i     (ratio_b),
    .done_o  (ratio_done),
    .err_o   (ratio_err)
  );

  always_comb begin
    state_d     = state_q;
    cross_d     = cross_q;
    mag_start   = 1'b0;
    ratio_start = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        if (accept && acc_last) begin
          cross_d = in_i.cross_mode;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (acc_done) begin
          if (cross_q) begin
            ratio_start = 1'b1;
            state_d     = ST_RATIO;
          end else begin
            mag_start = 1'b1;
            state_d   = ST_MAG;
          end
        end
      end
      ST_MAG: begin
        if (mag_l_done) begin
          ratio_start = 1'b1;
          state_d     = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (ratio_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hand over once the output register is free
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      cross_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cross_q     <= cross_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      avg_out_q <= avg;
      err_out_q <= ratio_err;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.avg_left_outer  = avg_to_out(avg_out_q[CH_LEFT_OUTER]);
  assign out_o.avg_left_inner  = avg_to_out(avg_out_q[CH_LEFT_INNER]);
  assign out_o.avg_middle      = avg_to_out(avg_out_q[CH_MIDDLE]);
  assign out_o.avg_right_inner = avg_to_out(avg_out_q[CH_RIGHT_INNER]);
  assign out_o.avg_right_outer = avg_to_out(avg_out_q[CH_RIGHT_OUTER]);
  assign out_o.position_error  = err_out_q;

  `ASSERT_IMPL(a_err_not_full_neg, out_o.valid, out_o.position_error != ERR_NEG_FULL)
  `ASSERT_IMPL(a_no_add_while_div, accept, !acc_busy)
  `ASSERT_IMPL(a_mag_lockstep, mag_l_done, mag_r_done)
  `ASSERT_NEXT(a_ratio_to_out, ratio_done, state_q == ST_OUT)

endmodule

[tb/inductor_position_error_tb.sv]
// ----------------------------------------------------------------------------
// inductor_position_error_tb
// Feeds sensor items to the position error block over its valid/ready
// channels; compares each result with a directed row's written-out value or
// a cycle-free model of channel averaging, square roots and the ratio.
// ----------------------------------------------------------------------------
module inductor_position_error_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipe_pkg::*;

  typedef logic [0:CHANNELS-1][SAMPLE_BITS-1:0] reading_in_t;

  typedef struct packed {
    logic [0:CHANNELS-1][AVG_OUT_W-1:0] avg;
    logic signed [ERR_W-1:0]            err;
  } reading_t;

  typedef struct packed {
    reading_in_t smp;
    logic        cross_on;
    logic        typed;
    reading_t    exp;
  } dir_row_t;

  localparam logic [SAMPLE_BITS-1:0] ZR = '0;
  localparam logic [SAMPLE_BITS-1:0] FS = '1;
  localparam logic [AVG_OUT_W-1:0]   A1 = AVG_OUT_W'(1);
  localparam logic [AVG_OUT_W-1:0]   AF = '1;

  localparam int DIR_ROWS         = 24;
  localparam int RANDOM_PER_PHASE = 308;
  localparam int LONG_HOLD        = 400;
  localparam int HOLD_AFTER       = 60;
  localparam int DRAIN_CYCLES     = 120;
  localparam int STALL_LIMIT      = 3000;

  // A reading is SAMPLES_PER_READING items; only its last row may carry a result.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // all zero, cross: every average clamps to 1
    '{{ZR, ZR, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{ZR, ZR, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{ZR, ZR, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{ZR, ZR, ZR, ZR, ZR}, 1'b1, 1'b1, '{{A1, A1, A1, A1, A1}, 16'sd0}},
    // full scale, vector: balanced
    '{{FS, FS, FS, FS, FS}, 1'b0, 1'b0, '0},
    '{{FS, FS, FS, FS, FS}, 1'b0, 1'b0, '0},
    '{{FS, FS, FS, FS, FS}, 1'b0, 1'b0, '0},
    '{{FS, FS, FS, FS, FS}, 1'b0, 1'b1, '{{AF, AF, AF, AF, AF}, 16'sd0}},
    // left full, cross: largest positive error
    '{{FS, ZR, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{FS, ZR, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{FS, ZR, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{FS, ZR, ZR, ZR, ZR}, 1'b1, 1'b1, '{{AF, A1, A1, A1, A1}, 16'sd32752}},
    // right full, cross: largest negative error
    '{{ZR, ZR, ZR, ZR, FS}, 1'b1, 1'b0, '0},
    '{{ZR, ZR, ZR, ZR, FS}, 1'b1, 1'b0, '0},
    '{{ZR, ZR, ZR, ZR, FS}, 1'b1, 1'b0, '0},
    '{{ZR, ZR, ZR, ZR, FS}, 1'b1, 1'b1, '{{A1, A1, A1, A1, AF}, -16'sd32752}},
    // left full, vector; mode flag on earlier items must not matter
    '{{FS, FS, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{FS, FS, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{FS, FS, ZR, ZR, ZR}, 1'b1, 1'b0, '0},
    '{{FS, FS, ZR, ZR, ZR}, 1'b0, 1'b0, '0},
    // floor of the average and clamp of small sums
    '{{12'd1, 12'd2, FS, FS, ZR},      1'b0, 1'b0, '0},
    '{{12'd1, ZR, FS, FS, ZR},         1'b1, 1'b0, '0},
    '{{12'd1, ZR, FS, 12'd4094, 12'd3}, 1'b1, 1'b0, '0},
    '{{ZR, ZR, FS, FS, ZR},            1'b0, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  ipe_in_if  in_if ();
  ipe_out_if out_if ();

  inductor_position_error uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [15:0]  ch_sum [CHANNELS];
  int unsigned  items_in_reading;
  reading_t     pending_readings [$];

  int unsigned  fail_count;
  int unsigned  items_sent;
  int unsigned  readings_cross;
  int unsigned  readings_vector;
  int unsigned  results_taken;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  int unsigned  stall_cycles;

  string avg_names [CHANNELS] = '{"avg_left_outer", "avg_left_inner", "avg_middle",
                                  "avg_right_inner", "avg_right_outer"};

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // trunc toward zero of 32768 * (a - b) / (a + b), saturated
  function automatic logic signed [ERR_W-1:0] q15_ratio(input longint unsigned a,
                                                        input longint unsigned b);
    longint unsigned total;
    longint unsigned diff;
    longint unsigned q;
    total = a + b;
    diff  = (a >= b) ? a - b : b - a;
    if (total == 0) return '0;
    q = (diff << 15) / total;
    if (q > 32767) q = 32767;
    return (a >= b) ? $signed(ERR_W'(q)) : -$signed(ERR_W'(q));
  endfunction

  // add one item to the channel sums; close the reading on its last item
  function automatic bit accumulate_item(input reading_in_t smp, input logic cross_on,
                                         output reading_t res);
    longint unsigned avg [CHANNELS];
    longint unsigned l_mag;
    longint unsigned r_mag;
    res = '0;
    for (int i = 0; i < CHANNELS; i++) ch_sum[i] += 16'(smp[i]);
    items_in_reading++;
    if (items_in_reading < N_EFF) return 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      avg[i] = ch_sum[i] / N_EFF;
      if (avg[i] < 1) avg[i] = 1;
      res.avg[i] = AVG_OUT_W'(avg[i]);
    end
    if (cross_on) begin
      res.err = q15_ratio(avg[CH_LEFT_OUTER], avg[CH_RIGHT_OUTER]);
      readings_cross++;
    end else begin
      l_mag = int_sqrt((avg[CH_LEFT_OUTER] * avg[CH_LEFT_OUTER] +
                        avg[CH_LEFT_INNER] * avg[CH_LEFT_INNER]) << MAG_SHIFT);
      r_mag = int_sqrt((avg[CH_RIGHT_INNER] * avg[CH_RIGHT_INNER] +
                        avg[CH_RIGHT_OUTER] * avg[CH_RIGHT_OUTER]) << MAG_SHIFT);
      res.err = q15_ratio(l_mag, r_mag);
      readings_vector++;
    end
    for (int i = 0; i < CHANNELS; i++) ch_sum[i] = '0;
    items_in_reading = 0;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_reading();
    case ($urandom_range(9))
      0:       return ZR;
      1:       return FS;
      2:       return SAMPLE_BITS'($urandom_range(3));
      3:       return SAMPLE_BITS'($urandom_range(4095, 4000));
      default: return SAMPLE_BITS'($urandom_range(4095));
    endcase
  endfunction

  task automatic feed_item(input reading_in_t smp, input logic cross_on,
                           input logic typed, input reading_t typed_exp);
    reading_t predicted;
    in_if.valid              <= 1'b1;
    in_if.sample_left_outer  <= smp[CH_LEFT_OUTER];
    in_if.sample_left_inner  <= smp[CH_LEFT_INNER];
    in_if.sample_middle      <= smp[CH_MIDDLE];
    in_if.sample_right_inner <= smp[CH_RIGHT_INNER];
    in_if.sample_right_outer <= smp[CH_RIGHT_OUTER];
    in_if.cross_mode         <= cross_on;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (accumulate_item(smp, cross_on, predicted))
      pending_readings.push_back(typed ? typed_exp : predicted);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // hold the sender until every outstanding result is back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  initial begin
    reading_in_t smp;
    rst_ni                   = 1'b0;
    in_if.valid              = 1'b0;
    in_if.sample_left_outer  = '0;
    in_if.sample_left_inner  = '0;
    in_if.sample_middle      = '0;
    in_if.sample_right_inner = '0;
    in_if.sample_right_outer = '0;
    in_if.cross_mode         = 1'b0;
    for (int i = 0; i < CHANNELS; i++) ch_sum[i] = '0;
    items_in_reading = 0;
    fail_count       = 0;
    items_sent       = 0;
    readings_cross   = 0;
    readings_vector  = 0;
    tx_idle_pct      = 35;
    rx_idle_pct      = 50;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      feed_item(DIRECTED[r].smp, DIRECTED[r].cross_on, DIRECTED[r].typed, DIRECTED[r].exp);
      idle_gap();
    end
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 35; rx_idle_pct = 50; end
        1:       begin tx_idle_pct = 50; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        for (int i = 0; i < CHANNELS; i++) smp[i] = rand_reading();
        feed_item(smp, 1'($urandom_range(1)), 1'b0, '0);
        idle_gap();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_readings.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_readings.size());
      fail_count++;
    end

    $display("Sent %0d items, checked %0d readings (%0d cross, %0d vector).",
             items_sent, results_taken, readings_cross, readings_vector);
    $display("Covered extremes, zero clamp, both modes, random stalls and a long hold.");
    if (fail_count == 0) begin
      $display("PASS inductor_position_error");
    end else begin
      $display("FAIL inductor_position_error");
    end
    $finish;
  end

  // result side: random stalls plus one long hold while the sender keeps offering items
  initial begin
    int unsigned hold_left;
    bit          long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    results_taken  = 0;
    out_if.ready   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && results_taken == HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        out_if.ready  <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    reading_t want;
    reading_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.avg[CH_LEFT_OUTER]  = out_if.avg_left_outer;
      got.avg[CH_LEFT_INNER]  = out_if.avg_left_inner;
      got.avg[CH_MIDDLE]      = out_if.avg_middle;
      got.avg[CH_RIGHT_INNER] = out_if.avg_right_inner;
      got.avg[CH_RIGHT_OUTER] = out_if.avg_right_outer;
      got.err                 = out_if.position_error;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result, err %0d", $time, got.err);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        for (int i = 0; i < CHANNELS; i++) begin
          if (got.avg[i] !== want.avg[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, avg_names[i],
                     want.avg[i], got.avg[i]);
            fail_count++;
          end
        end
        if (got.err !== want.err) begin
          $display("%0t: position_error expected %0d actual %0d", $time, want.err, got.err);
          fail_count++;
        end
      end
    end
  end

  // end the run if neither side moves an item for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL inductor_position_error");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ipe_pkg.sv
rtl/ipe_if.sv
rtl/ipe_accum.sv
rtl/ipe_mag.sv
rtl/ipe_ratio.sv
rtl/inductor_position_error.sv
tb/inductor_position_error_tb.sv
